FILE: hw/rtl/small_key_set_swap_remove_defines.svh
// Assertion macros shared by the small key set RTL.
`ifndef SMALL_KEY_SET_SWAP_REMOVE_DEFINES_SVH
`define SMALL_KEY_SET_SWAP_REMOVE_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define SKSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SKSR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hw/rtl/sksr_pkg.sv
// Shared types and constants of the small key set.
package sksr_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_W      = 64;
  localparam int SLOT_IDX_W = 6;
  localparam int CNT_OUT_W  = 5;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = (CNT_W > SLOT_IDX_W) ? CNT_W : SLOT_IDX_W;

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_ERASE    = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_GET      = 2'd3
  } op_e;

  typedef enum logic {
    ST_LOOK   = 1'b0,
    ST_COMMIT = 1'b1
  } state_e;

  // Classified request as it travels from the front to the back.
  typedef struct packed {
    op_e                   op;
    logic [KEY_W-1:0]      key;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  key_nz;
  } req_t;

  typedef struct packed {
    logic                 success;
    logic                 full_reject;
    logic [KEY_W-1:0]     entry_value;
    logic [CNT_OUT_W-1:0] member_count;
  } res_t;

endpackage

FILE: hw/rtl/sksr_front.sv
// Front end: accept requests and classify them for the back end.
module sksr_front (
  input  logic                            push_i,
  input  logic [1:0]                      req_type_i,
  input  logic [sksr_pkg::KEY_W-1:0]      key_i,
  input  logic [sksr_pkg::SLOT_IDX_W-1:0] slot_index_i,
  input  logic                            q_full_i,
  output logic                            q_wr_en_o,
  output sksr_pkg::req_t                  q_wr_data_o
);

  always_comb begin
    q_wr_en_o              = push_i && !q_full_i;
    q_wr_data_o.op         = sksr_pkg::op_e'(req_type_i);
    q_wr_data_o.key        = key_i;
    q_wr_data_o.slot_index = slot_index_i;
    // Key zero is never a member; flag it once here.
    q_wr_data_o.key_nz     = |key_i;
  end

endmodule

FILE: hw/rtl/sksr_fifo.sv
// Short request queue between the front and back ends.
module sksr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  sksr_pkg::req_t wr_data_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output logic           valid_o,
  output sksr_pkg::req_t rd_data_o
);

  sksr_pkg::req_t                  mem_q [sksr_pkg::Q_DEPTH];
  logic [sksr_pkg::Q_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [sksr_pkg::Q_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [sksr_pkg::Q_CNT_W-1:0]    cnt_q, cnt_d;
  logic                            do_wr, do_rd;

  assign full_o    = (cnt_q == sksr_pkg::Q_CNT_W'(sksr_pkg::Q_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == sksr_pkg::Q_PTR_W'(sksr_pkg::Q_DEPTH - 1)) ? '0
               : wr_ptr_q + sksr_pkg::Q_PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == sksr_pkg::Q_PTR_W'(sksr_pkg::Q_DEPTH - 1)) ? '0
               : rd_ptr_q + sksr_pkg::Q_PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + sksr_pkg::Q_CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - sksr_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: hw/rtl/sksr_back.sv
// Back end: slot store, parallel key lookup, update and result register.
module sksr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  sksr_pkg::req_t head_i,
  output logic           head_pop_o,
  output logic           res_valid_o,
  output sksr_pkg::res_t res_o,
  input  logic           res_pop_i
);

  sksr_pkg::state_e                 state_q, state_d;
  logic [sksr_pkg::KEY_W-1:0]       slots_q [sksr_pkg::CAPACITY];
  logic [sksr_pkg::CNT_W-1:0]       count_q, count_d, cnt_m1;
  logic [sksr_pkg::CAPACITY-1:0]    match;
  logic [sksr_pkg::IDX_W-1:0]       pos_d, rd_addr;
  logic                             hit_d, get_ok_d, is_full_d;

  // Lookup results held for the update cycle.
  sksr_pkg::req_t                   req_q;
  logic                             hit_q, get_ok_q, is_full_q;
  logic [sksr_pkg::IDX_W-1:0]       pos_q;
  logic [sksr_pkg::KEY_W-1:0]       rd_data_q;

  logic                             look_en, commit, out_ready;
  logic                             slot_we;
  logic [sksr_pkg::IDX_W-1:0]       slot_waddr;
  logic [sksr_pkg::KEY_W-1:0]       slot_wdata;
  logic                             out_valid_q;
  sksr_pkg::res_t                   res_q, res_d;

  assign out_ready   = !out_valid_q || res_pop_i;
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign cnt_m1      = count_q - sksr_pkg::CNT_W'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sksr_pkg::ST_LOOK: begin
        if (head_valid_i) begin
          state_d = sksr_pkg::ST_COMMIT;
        end
      end
      sksr_pkg::ST_COMMIT: begin
        if (out_ready) begin
          state_d = sksr_pkg::ST_LOOK;
        end
      end
      default: state_d = sksr_pkg::ST_LOOK;
    endcase
  end

  // State outputs.
  always_comb begin
    look_en = 1'b0;
    commit  = 1'b0;
    case (state_q)
      sksr_pkg::ST_LOOK:   look_en = head_valid_i;
      sksr_pkg::ST_COMMIT: commit  = out_ready;
      default: begin
        look_en = 1'b0;
        commit  = 1'b0;
      end
    endcase
  end

  assign head_pop_o = look_en;

  // Compare every held slot against the head key.
  always_comb begin
    pos_d = '0;
    for (int i = 0; i < sksr_pkg::CAPACITY; i++) begin
      match[i] = head_i.key_nz && (sksr_pkg::CNT_W'(i) < count_q)
              && (slots_q[i] == head_i.key);
      pos_d    = pos_d | (match[i] ? sksr_pkg::IDX_W'(i) : '0);
    end
    hit_d     = |match;
    get_ok_d  = sksr_pkg::CMP_W'(head_i.slot_index) < sksr_pkg::CMP_W'(count_q);
    is_full_d = (count_q == sksr_pkg::CNT_W'(sksr_pkg::CAPACITY));
    // Get reads the named slot; erase reads the last one to move it down.
    rd_addr   = (head_i.op == sksr_pkg::OP_GET) ? head_i.slot_index[sksr_pkg::IDX_W-1:0]
              : cnt_m1[sksr_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (look_en) begin
      req_q     <= head_i;
      hit_q     <= hit_d;
      pos_q     <= pos_d;
      get_ok_q  <= get_ok_d;
      is_full_q <= is_full_d;
      rd_data_q <= slots_q[rd_addr];
    end
  end

  // Update and result.
  always_comb begin
    slot_we          = 1'b0;
    slot_waddr       = pos_q;
    slot_wdata       = rd_data_q;
    count_d          = count_q;
    res_d.success     = 1'b0;
    res_d.full_reject = 1'b0;
    res_d.entry_value = '0;
    case (req_q.op)
      sksr_pkg::OP_INSERT: begin
        if (req_q.key_nz && !hit_q) begin
          if (is_full_q) begin
            res_d.full_reject = 1'b1;
          end else begin
            slot_we       = 1'b1;
            slot_waddr    = count_q[sksr_pkg::IDX_W-1:0];
            slot_wdata    = req_q.key;
            count_d       = count_q + sksr_pkg::CNT_W'(1);
            res_d.success = 1'b1;
          end
        end
      end
      sksr_pkg::OP_ERASE: begin
        if (hit_q) begin
          slot_we       = 1'b1;
          count_d       = cnt_m1;
          res_d.success = 1'b1;
        end
      end
      sksr_pkg::OP_CONTAINS: res_d.success = hit_q;
      sksr_pkg::OP_GET: begin
        res_d.success     = get_ok_q;
        res_d.entry_value = get_ok_q ? rd_data_q : '0;
      end
      default: res_d.success = 1'b0;
    endcase
    res_d.member_count = sksr_pkg::CNT_OUT_W'(count_d);
  end

  always_ff @(posedge clk_i) begin
    if (commit && slot_we) begin
      slots_q[slot_waddr] <= slot_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sksr_pkg::ST_LOOK;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        count_q <= count_d;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/small_key_set_swap_remove.sv
// Top level of the small key set with swap-with-last removal.
//
//  channel   direction  handshake           fields
//  request   in         push / full         req_type_i, key_i, slot_index_i
//  result    out        empty / pop         success_o, full_reject_o,
//                                            entry_value_o, member_count_o
//
// Each request passes through the back end in ST_LOOK, which compares the key
// against all held slots in parallel and reads one slot, then ST_COMMIT, which
// writes the slot store and loads the result register. Since each request
// depends on the store left by the one before, a new one waits for that commit.
// Reset clears the count, the queue and the result valid flag; no clearing pass.
// A two-entry queue lets requests arrive while the back end waits on pop.
`include "small_key_set_swap_remove_defines.svh"

module small_key_set_swap_remove (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      req_type_i,
  input  logic [sksr_pkg::KEY_W-1:0]      key_i,
  input  logic [sksr_pkg::SLOT_IDX_W-1:0] slot_index_i,
  output logic                            empty,
  input  logic                            pop,
  output logic                            success_o,
  output logic                            full_reject_o,
  output logic [sksr_pkg::KEY_W-1:0]      entry_value_o,
  output logic [sksr_pkg::CNT_OUT_W-1:0]  member_count_o
);

  // Front to queue.
  logic           q_wr_en;
  sksr_pkg::req_t q_wr_data;

  // Queue to back.
  logic           q_valid;
  logic           q_rd_en;
  sksr_pkg::req_t q_head;

  // Result register.
  logic           res_valid;
  sksr_pkg::res_t res;

  // Classify incoming transactions.
  sksr_front u_front (
    .push_i       (push),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .slot_index_i (slot_index_i),
    .q_full_i     (full),
    .q_wr_en_o    (q_wr_en),
    .q_wr_data_o  (q_wr_data)
  );

  // Hold classified requests until the back end is free.
  sksr_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_wr_en),
    .wr_data_i (q_wr_data),
    .full_o    (full),
    .rd_en_i   (q_rd_en),
    .valid_o   (q_valid),
    .rd_data_o (q_head)
  );

  // Look up, update the store and advance results to the output register.
  sksr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .head_pop_o   (q_rd_en),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop)
  );

  assign empty          = !res_valid;
  assign success_o      = res.success;
  assign full_reject_o  = res.full_reject;
  assign entry_value_o  = res.entry_value;
  assign member_count_o = res.member_count;

  // Coming out of reset nothing is waiting on either side.
  `SKSR_ASSERT_ALWAYS(a_reset_idle, $rose(rst_ni) |-> (empty && !full), "reset not idle")
  // A set is never both accepted and rejected as full.
  `SKSR_ASSERT(a_flags_excl, !empty |-> !(success_o && full_reject_o), "success with full reject")
  // Only a successful get returns a nonzero entry.
  `SKSR_ASSERT(a_value_ok, (!empty && (entry_value_o != '0)) |-> success_o, "value without success")
  // A result that was not taken is still there on the next edge.
  `SKSR_ASSERT(a_res_hold, (!empty && !pop) |=> !empty, "result dropped")

endmodule

FILE: tb/sv/small_key_set_swap_remove_tb.sv
// Self-checking testbench of the small key set with swap-with-last removal.
`timescale 1ns / 100ps

module small_key_set_swap_remove_tb;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any transaction
  localparam int MAX_SEND_GAP   = 20;
  localparam int POOL_SIZE      = 24;    // more keys than slots, so the set fills up

  logic                            clk_i        = 1'b0;
  logic                            rst_ni       = 1'b0;
  logic                            push         = 1'b0;
  logic                            full;
  logic [1:0]                      req_type_i   = sksr_pkg::OP_GET;
  logic [sksr_pkg::KEY_W-1:0]      key_i        = '0;
  logic [sksr_pkg::SLOT_IDX_W-1:0] slot_index_i = '0;
  logic                            empty;
  logic                            pop          = 1'b0;
  logic                            success_o;
  logic                            full_reject_o;
  logic [sksr_pkg::KEY_W-1:0]      entry_value_o;
  logic [sksr_pkg::CNT_OUT_W-1:0]  member_count_o;

  small_key_set_swap_remove uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type_i),
    .key_i          (key_i),
    .slot_index_i   (slot_index_i),
    .empty          (empty),
    .pop            (pop),
    .success_o      (success_o),
    .full_reject_o  (full_reject_o),
    .entry_value_o  (entry_value_o),
    .member_count_o (member_count_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the set, kept dense exactly like the block keeps it.
  logic [sksr_pkg::KEY_W-1:0] held_keys [sksr_pkg::CAPACITY];
  int                         held_count = 0;
  logic [sksr_pkg::KEY_W-1:0] key_pool  [POOL_SIZE];

  sksr_pkg::res_t expected_results [$];
  sksr_pkg::res_t oldest_result;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles  = 0;
  int error_count   = 0;
  int n_requests    = 0;
  int n_results     = 0;
  int n_rejects     = 0;
  int n_emptied     = 0;
  int peak_count    = 0;

  // Compute the result of one request and advance the shadow set.
  function automatic sksr_pkg::res_t predict_request(sksr_pkg::op_e op,
                                                     logic [sksr_pkg::KEY_W-1:0] key,
                                                     logic [sksr_pkg::SLOT_IDX_W-1:0] idx);
    sksr_pkg::res_t r;
    int             pos;
    r   = '0;
    pos = -1;
    if (key != '0) begin
      for (int i = 0; i < held_count; i++) begin
        if (held_keys[i] == key) pos = i;
      end
    end
    case (op)
      sksr_pkg::OP_INSERT: begin
        if (key != '0 && pos < 0) begin
          if (held_count >= sksr_pkg::CAPACITY) begin
            r.full_reject = 1'b1;
            n_rejects++;
          end else begin
            held_keys[held_count] = key;
            held_count++;
            r.success = 1'b1;
          end
        end
      end
      sksr_pkg::OP_ERASE: begin
        // Fill the hole with the last entry; the last slot is then dropped.
        if (pos >= 0) begin
          held_keys[pos] = held_keys[held_count-1];
          held_count--;
          r.success = 1'b1;
          if (held_count == 0) n_emptied++;
        end
      end
      sksr_pkg::OP_CONTAINS: begin
        r.success = (pos >= 0);
      end
      default: begin
        if (int'(idx) < held_count) begin
          r.entry_value = held_keys[idx];
          r.success     = 1'b1;
        end
      end
    endcase
    r.member_count = held_count[sksr_pkg::CNT_OUT_W-1:0];
    if (held_count > peak_count) peak_count = held_count;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [sksr_pkg::KEY_W-1:0] got,
                                 logic [sksr_pkg::KEY_W-1:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Send one request; return at the edge where it is accepted, push still high.
  task automatic send_request(sksr_pkg::op_e op, logic [sksr_pkg::KEY_W-1:0] key,
                              logic [sksr_pkg::SLOT_IDX_W-1:0] idx);
    int gap;
    gap = 0;
    while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    req_type_i   <= op;
    key_i        <= key;
    slot_index_i <= idx;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    expected_results.insert(expected_results.size(), predict_request(op, key, idx));
    n_requests++;
  endtask

  // Hold off the sender until every outstanding result has been popped.
  task automatic wait_for_results;
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Empty set: key zero on every key operation, a miss, and a read past the end.
  task automatic test_empty_set;
    send_request(sksr_pkg::OP_INSERT,   '0,         '0);
    send_request(sksr_pkg::OP_ERASE,    '0,         '0);
    send_request(sksr_pkg::OP_CONTAINS, '0,         '0);
    send_request(sksr_pkg::OP_ERASE,    64'h5a5a_0000_0000_0001, '0);
    send_request(sksr_pkg::OP_GET,      '0,         '1);
  endtask

  // Fill to capacity, then hit the full-set cases and a swap-with-last erase.
  task automatic test_fill_and_reject;
    logic [sksr_pkg::KEY_W-1:0] k;
    for (int i = 0; i < sksr_pkg::CAPACITY; i++) begin
      case (i)
        0:       k = '1;
        1:       k = 64'h1;
        2:       k = 64'h8000_0000_0000_0000;
        3:       k = 64'h5555_5555_5555_5555;
        4:       k = 64'haaaa_aaaa_aaaa_aaaa;
        default: k = {$urandom, $urandom} | 64'h1;
      endcase
      send_request(sksr_pkg::OP_INSERT, k, '0);
    end
    send_request(sksr_pkg::OP_INSERT, '1, '0);                        // duplicate while full
    send_request(sksr_pkg::OP_INSERT, 64'h0123_4567_89ab_cdef, '0);   // new key while full
    send_request(sksr_pkg::OP_GET,    '0,
                 sksr_pkg::SLOT_IDX_W'(sksr_pkg::CAPACITY - 1));
    send_request(sksr_pkg::OP_ERASE,  '1, '0);                        // last entry moves to slot 0
    send_request(sksr_pkg::OP_GET,    '0, '0);
  endtask

  // Mostly well-formed traffic: keys from a small pool or already held, so
  // hits, duplicates and full rejects are common; a few zero and wild keys.
  task automatic test_random_traffic(int n_items, int s_pct, int r_pct);
    sksr_pkg::op_e                   op;
    logic [sksr_pkg::KEY_W-1:0]      k;
    logic [sksr_pkg::SLOT_IDX_W-1:0] idx;
    int                              roll;
    bit                              grow;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    foreach (key_pool[i]) begin
      key_pool[i] = {$urandom, $urandom};
      if (key_pool[i] == '0) key_pool[i] = 64'h1;
    end
    for (int n = 0; n < n_items; n++) begin
      // Alternate growing and shrinking stretches so the count sweeps the range.
      grow = ((n / 40) % 2) == 0;
      roll = $urandom_range(99);
      if (roll < 20)                    op = sksr_pkg::OP_GET;
      else if (roll < 40)               op = sksr_pkg::OP_CONTAINS;
      else if (roll < (grow ? 85 : 55)) op = sksr_pkg::OP_INSERT;
      else                              op = sksr_pkg::OP_ERASE;

      roll = $urandom_range(99);
      if (roll < 5)                            k = '0;
      else if (roll < 15)                      k = {$urandom, $urandom};
      else if (roll < 60 && held_count > 0)    k = held_keys[$urandom_range(held_count - 1)];
      else                                     k = key_pool[$urandom_range(POOL_SIZE - 1)];

      if ($urandom_range(99) < 60) idx = sksr_pkg::SLOT_IDX_W'($urandom_range(held_count));
      else                         idx = sksr_pkg::SLOT_IDX_W'($urandom_range(63));

      send_request(op, k, idx);
    end
  endtask

  // Check each popped result against the oldest expectation, drive pop, and
  // count cycles with no transaction for the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
      else                                    stall_cycles <= stall_cycles + 1;
      if (pop && !empty) begin
        n_results++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with none outstanding", entry_value_o, '0);
        end else begin
          oldest_result = expected_results.pop_front();
          if (success_o !== oldest_result.success)
            report_mismatch("success", success_o, oldest_result.success);
          if (full_reject_o !== oldest_result.full_reject)
            report_mismatch("full_reject", full_reject_o, oldest_result.full_reject);
          if (entry_value_o !== oldest_result.entry_value)
            report_mismatch("entry_value", entry_value_o, oldest_result.entry_value);
          if (member_count_o !== oldest_result.member_count)
            report_mismatch("member_count", member_count_o, oldest_result.member_count);
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // End the run if the handshakes stop moving.
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("** small_key_set_swap_remove: FAILED **");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Slow receiver first, then slow sender, then both at full rate.
    send_idle_pct = 18;
    recv_idle_pct = 77;
    test_empty_set();
    test_fill_and_reject();
    wait_for_results();
    test_random_traffic(480, 18, 77);
    wait_for_results();
    test_random_traffic(480, 77, 18);
    wait_for_results();
    test_random_traffic(490, 0, 0);
    wait_for_results();

    // Let the back end settle after the last pop.
    repeat (4) @(posedge clk_i);

    $display("Ran %0d requests over three idle mixes, %0d results checked, %0d mismatches.",
             n_requests, n_results, error_count);
    $display("Set peaked at %0d keys, drained to empty %0d times, %0d full-set inserts rejected.",
             peak_count, n_emptied, n_rejects);
    if (error_count == 0) begin
      $display("** small_key_set_swap_remove: PASSED **");
    end else begin
      $display("** small_key_set_swap_remove: FAILED **");
    end
    $finish;
  end

endmodule
